/* sv/sigmoid_neuron_delta_rule_trainer_macros.svh */
// Assertion macros shared by the neuron trainer RTL.
`ifndef SIGMOID_NEURON_DELTA_RULE_TRAINER_MACROS_SVH
`define SIGMOID_NEURON_DELTA_RULE_TRAINER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SND_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define SND_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SND_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SND_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* sv/snd_pkg.sv */
// Types, constants and helper functions for the sigmoid neuron trainer.
package snd_pkg;

  localparam int ACT_W  = 13;
  localparam int ERR_W  = 14;
  localparam int W_W    = 24;
  localparam int X_W    = 16;
  localparam int TGT_W  = 13;
  localparam int MODE_W = 2;
  localparam int RS_W   = 4;
  localparam int CIDX_W = 2;
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DOT_W   = 41;
  localparam int PRE_W   = 30;
  localparam int D_W     = 16;

  localparam logic [ACT_W-1:0] ONE_Q12  = 13'd4096;
  localparam logic [ACT_W-1:0] HALF_Q12 = 13'd2048;

  localparam logic [MODE_W-1:0] MODE_TRAIN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELOAD = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_INIT_WA   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_INIT_WB   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_INIT_BIAS = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_RATE      = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_ROM,
    ST_ACT,
    ST_ERR,
    ST_ERR_SCALE,
    ST_DELTA,
    ST_MUL_DA,
    ST_MUL_DB,
    ST_UPD_B,
    ST_DONE
  } snd_state_e;

  typedef enum logic [2:0] {
    MUL_W_A,
    MUL_W_B,
    MUL_ERR_ACT,
    MUL_ERR_SCALE,
    MUL_D_A,
    MUL_D_B
  } snd_mul_sel_e;

  typedef struct packed {
    logic         idle;
    logic         in_take;
    logic         mul_en;
    snd_mul_sel_e mul_sel;
    logic         acc_load;
    logic         idx_load;
    logic         act_load;
    logic         reload;
    logic         err_load;
    logic         d_load;
    logic         bias_upd;
    logic         wa_upd;
    logic         wb_upd;
    logic         out_load;
  } snd_ctl_t;

  // Clamp a 25-bit sum to the signed 24-bit range.
  function automatic logic [W_W-1:0] sat24(logic [W_W:0] v);
    logic [W_W-1:0] r;
    if (v[W_W] != v[W_W-1]) begin
      r = v[W_W] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
    end else begin
      r = v[W_W-1:0];
    end
    return r;
  endfunction

  // Unsigned floor quotient by shift and subtract; only evaluated while building tables.
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f/65536) in Q.30 as a 16-term alternating series; used to build the table.
  function automatic longint unsigned exp_neg_frac(longint unsigned f);
    longint          acc;
    longint unsigned t;
    acc = 0;
    t   = 64'd1 << 30;
    for (int k = 0; k < 16; k++) begin
      if ((k & 1) == 1) begin
        acc = acc - longint'(t);
      end else begin
        acc = acc + longint'(t);
      end
      t = udiv64(t * f, 64'd65536 * longint'(k + 1));
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

endpackage

/* sv/sigmoid_neuron_delta_rule_trainer.sv */
// Infer/reload items step through MUL_A, MUL_B, SUM, ROM, ACT and DONE; training items
// also pass ERR, ERR_SCALE, DELTA, MUL_DA, MUL_DB and UPD_B. One shared 28x24 multiplier
// carries both dot-product terms and the four delta-rule products in turn.
// The input side stalls from accept until the result is loaded into the output register.
// Reset (async, active low) clears weights, bias, config registers and control state.
// Configuration writes are always taken and should only happen while the block is idle.
`include "sigmoid_neuron_delta_rule_trainer_macros.svh"

module sigmoid_neuron_delta_rule_trainer #(
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input item channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [snd_pkg::MODE_W-1:0]            mode_i,
  input  logic signed [snd_pkg::X_W-1:0]        x_a_i,
  input  logic signed [snd_pkg::X_W-1:0]        x_b_i,
  input  logic [snd_pkg::TGT_W-1:0]             target_i,
  // result item channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [snd_pkg::ACT_W-1:0]             activation_o,
  output logic                                  decision_o,
  output logic signed [snd_pkg::ERR_W-1:0]      train_error_o,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [snd_pkg::CIDX_W-1:0]            cfg_index_i,
  input  logic [snd_pkg::W_W-1:0]               cfg_data_i
);
  import snd_pkg::*;

  localparam int IDX_W   = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int DEPTH_W = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int SCL_W   = 16 + DEPTH_W;

  // Configuration registers
  logic [W_W-1:0]  init_wa_q, init_wb_q, init_bias_q;
  logic [RS_W-1:0] rate_shift_q;

  // Neuron state
  logic [W_W-1:0] wa_q, wb_q, bias_q;

  // Item registers
  logic [MODE_W-1:0]       mode_q;
  logic signed [X_W-1:0]   xa_q, xb_q;
  logic [TGT_W-1:0]        tgt_q;

  // Datapath registers
  logic signed [DOT_W-1:0] acc_q;
  logic [IDX_W-1:0]        idx_q;
  logic [ACT_W-1:0]        act_q;
  logic signed [ERR_W-1:0] err_q;
  logic signed [D_W-1:0]   d_q;

  // Output register
  logic                    out_valid_q;
  logic [ACT_W-1:0]        out_act_q;
  logic                    out_dec_q;
  logic signed [ERR_W-1:0] out_err_q;

  snd_state_e state;
  snd_ctl_t   ctl;
  logic       train;
  logic       out_free;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [ACT_W-1:0]          rom_data;

  logic signed [DOT_W-1:0]  dot_sum;
  logic signed [PRE_W-1:0]  pre_act;
  logic [15:0]              pre_off;
  logic [SCL_W-1:0]         pre_scaled;
  logic [TGT_W-1:0]         tgt_clamp;
  logic signed [ERR_W-1:0]  err;
  logic [ACT_W-1:0]         act_comp;
  logic [5:0]               d_shift;
  logic signed [PROD_W-1:0] d_full;
  logic signed [PROD_W-1:0] dx_full;

  assign train    = (mode_q == MODE_TRAIN);
  assign out_free = !(out_valid_q && out_stall_i);

  snd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .train_i    (train),
    .out_free_i (out_free),
    .state_o    (state),
    .ctl_o      (ctl)
  );

  // Hold the input side off for the whole item.
  assign in_stall_o  = !ctl.idle;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; all four index values select a register, so the case default is never taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_wa_q    <= '0;
      init_wb_q    <= '0;
      init_bias_q  <= '0;
      rate_shift_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INIT_WA:   init_wa_q    <= cfg_data_i;
        CFG_INIT_WB:   init_wb_q    <= cfg_data_i;
        CFG_INIT_BIAS: init_bias_q  <= cfg_data_i;
        CFG_RATE:      rate_shift_q <= cfg_data_i[RS_W-1:0];
        default:       rate_shift_q <= rate_shift_q;
      endcase
    end
  end

  // Latch the item on accept.
  always_ff @(posedge clk_i) begin
    if (ctl.in_take) begin
      mode_q <= mode_i;
      xa_q   <= x_a_i;
      xb_q   <= x_b_i;
      tgt_q  <= target_i;
    end
  end

  // Clamp target to one and form the error against the activation.
  assign tgt_clamp = (tgt_q > ONE_Q12) ? ONE_Q12 : tgt_q;
  assign err       = $signed({1'b0, tgt_clamp}) - $signed({1'b0, act_q});
  assign act_comp  = ONE_Q12 - act_q;

  // Shared multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.mul_sel)
      MUL_W_A: begin
        mul_a = MUL_A_W'($signed(wa_q));
        mul_b = MUL_B_W'(xa_q);
      end
      MUL_W_B: begin
        mul_a = MUL_A_W'($signed(wb_q));
        mul_b = MUL_B_W'(xb_q);
      end
      MUL_ERR_ACT: begin
        mul_a = MUL_A_W'(err);
        mul_b = $signed(MUL_B_W'(act_q));
      end
      MUL_ERR_SCALE: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = $signed(MUL_B_W'(act_comp));
      end
      MUL_D_A: begin
        mul_a = MUL_A_W'(d_q);
        mul_b = MUL_B_W'(xa_q);
      end
      MUL_D_B: begin
        mul_a = MUL_A_W'(d_q);
        mul_b = MUL_B_W'(xb_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  snd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctl.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Pre-activation: bias plus floored dot product, clamped to [-8,8) and scaled to an index.
  assign dot_sum    = acc_q + prod[DOT_W-1:0];
  assign pre_act    = PRE_W'($signed(bias_q)) + PRE_W'(dot_sum >>> 12);
  always_comb begin
    if (pre_act < -PRE_W'(32768)) begin
      pre_off = 16'h0000;
    end else if (pre_act > PRE_W'(32767)) begin
      pre_off = 16'hFFFF;
    end else begin
      pre_off = pre_act[15:0] ^ 16'h8000;
    end
  end
  assign pre_scaled = SCL_W'(pre_off) * SCL_W'(SIGMOID_TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (ctl.acc_load) acc_q <= prod[DOT_W-1:0];
    if (ctl.idx_load) idx_q <= pre_scaled[16 +: IDX_W];
    if (ctl.act_load) act_q <= rom_data;
    if (ctl.err_load) err_q <= err;
    if (ctl.d_load)   d_q   <= d_full[D_W-1:0];
  end

  snd_rom #(
    .DEPTH (SIGMOID_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (idx_q),
    .data_o (rom_data)
  );

  // Delta: err*act*(1-act) floored by 2^(24+rate_shift).
  assign d_shift = 6'd24 + 6'(rate_shift_q);
  assign d_full  = prod >>> d_shift;
  assign dx_full = prod >>> 12;

  // Weight and bias write-back; reload from configuration on a reload item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q   <= '0;
      wb_q   <= '0;
      bias_q <= '0;
    end else begin
      if (ctl.reload && (mode_q == MODE_RELOAD)) begin
        wa_q   <= init_wa_q;
        wb_q   <= init_wb_q;
        bias_q <= init_bias_q;
      end
      if (ctl.bias_upd) begin
        bias_q <= sat24({bias_q[W_W-1], bias_q} + (W_W+1)'(d_q));
      end
      if (ctl.wa_upd) begin
        wa_q <= sat24({wa_q[W_W-1], wa_q} + dx_full[W_W:0]);
      end
      if (ctl.wb_upd) begin
        wb_q <= sat24({wb_q[W_W-1], wb_q} + dx_full[W_W:0]);
      end
    end
  end

  // Output register; it frees up as soon as the waiting result is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      out_act_q <= act_q;
      out_dec_q <= (act_q > HALF_Q12);
      out_err_q <= train ? err_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign activation_o  = out_act_q;
  assign decision_o    = out_dec_q;
  assign train_error_o = out_err_q;

  // An accepted item keeps the input side stalled on the following cycle.
  `SND_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // A new result never overwrites one that is still waiting.
  `SND_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, ctl.out_load, !(out_valid_q && out_stall_i))
  // Results are only loaded from the final sequencer step.
  `SND_ASSERT_IMP(a_load_in_done, clk_i, rst_ni, ctl.out_load, state == ST_DONE)
  // The table never yields an activation above one.
  `SND_ASSERT_IMP(a_act_range, clk_i, rst_ni, out_valid_o, activation_o <= ONE_Q12)

endmodule

/* sv/snd_mul.sv */
// Shared signed multiplier with a registered product.
module snd_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [snd_pkg::MUL_A_W-1:0]   a_i,
  input  logic signed [snd_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [snd_pkg::PROD_W-1:0]    prod_o
);
  import snd_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

/* sv/snd_rom.sv */
// Sigmoid lookup table over [-8,8) with a registered read port.
module snd_rom #(
  parameter int DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic [$clog2(DEPTH)-1:0]     addr_i,
  output logic [snd_pkg::ACT_W-1:0]    data_o
);
  import snd_pkg::*;

  typedef logic [ACT_W-1:0] rom_t [DEPTH];

  // Entry i sits at the midpoint of bin i, in Q.16.
  function automatic rom_t build_rom();
    rom_t            rom;
    longint          x;
    longint unsigned a;
    longint unsigned n;
    longint unsigned e;
    longint unsigned e1;
    longint unsigned den;
    longint unsigned num;
    e1 = exp_neg_frac(64'd65536);
    for (int i = 0; i < DEPTH; i++) begin
      x = longint'(udiv64(64'(2 * i + 1) * 64'd524288, 64'(DEPTH))) - 64'sd524288;
      a = (x < 0) ? longint'(-x) : longint'(x);
      n = a >> 16;
      e = exp_neg_frac(a & 64'hFFFF);
      for (int j = 0; j < 8; j++) begin
        if (longint'(j) < longint'(n)) begin
          e = (e * e1) >> 30;
        end
      end
      den = (64'd1 << 30) + e;
      num = (x >= 0) ? (64'd1 << 30) : e;
      rom[i] = ACT_W'(udiv64(num * 64'd4096 + (den >> 1), den));
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [ACT_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

/* sv/snd_seq.sv */
// Sequencer that steps one item through the shared multiplier.
module snd_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                train_i,
  input  logic                out_free_i,
  output snd_pkg::snd_state_e state_o,
  output snd_pkg::snd_ctl_t   ctl_o
);
  import snd_pkg::*;

  snd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_MUL_A;
      ST_MUL_A:     state_d = ST_MUL_B;
      ST_MUL_B:     state_d = ST_SUM;
      ST_SUM:       state_d = ST_ROM;
      ST_ROM:       state_d = ST_ACT;
      ST_ACT:       state_d = train_i ? ST_ERR : ST_DONE;
      ST_ERR:       state_d = ST_ERR_SCALE;
      ST_ERR_SCALE: state_d = ST_DELTA;
      ST_DELTA:     state_d = ST_MUL_DA;
      ST_MUL_DA:    state_d = ST_MUL_DB;
      ST_MUL_DB:    state_d = ST_UPD_B;
      ST_UPD_B:     state_d = ST_DONE;
      ST_DONE:      if (out_free_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o         = '0;
    ctl_o.mul_sel = MUL_W_A;
    unique case (state_q)
      ST_IDLE: begin
        ctl_o.idle    = 1'b1;
        ctl_o.in_take = in_valid_i;
      end
      ST_MUL_A: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_W_A;
      end
      ST_MUL_B: begin
        ctl_o.mul_en   = 1'b1;
        ctl_o.mul_sel  = MUL_W_B;
        ctl_o.acc_load = 1'b1;
      end
      ST_SUM:   ctl_o.idx_load = 1'b1;
      ST_ROM:   ctl_o.idle = 1'b0;
      ST_ACT: begin
        ctl_o.act_load = 1'b1;
        ctl_o.reload   = 1'b1;
      end
      ST_ERR: begin
        ctl_o.mul_en   = 1'b1;
        ctl_o.mul_sel  = MUL_ERR_ACT;
        ctl_o.err_load = 1'b1;
      end
      ST_ERR_SCALE: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_ERR_SCALE;
      end
      ST_DELTA: ctl_o.d_load = 1'b1;
      ST_MUL_DA: begin
        ctl_o.mul_en   = 1'b1;
        ctl_o.mul_sel  = MUL_D_A;
        ctl_o.bias_upd = 1'b1;
      end
      ST_MUL_DB: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_D_B;
        ctl_o.wa_upd  = 1'b1;
      end
      ST_UPD_B: ctl_o.wb_upd = 1'b1;
      ST_DONE:  ctl_o.out_load = out_free_i;
      default:  ctl_o.idle = 1'b0;
    endcase
  end

  assign state_o = state_q;

endmodule
